// ===== sv/sud_pkg.sv =====
// Shared types, constants and helpers for the restoring divider pipeline.
// Used by every module of the divider; depends on nothing.

package sud_pkg;

   // Operand width and the fixed width of the ports
   localparam int DATA_WIDTH = 64;
   localparam int PORT_WIDTH = 64;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // State carried by one pipeline stage
   typedef struct packed {
      logic     valid;
      word_type rem;    // partial remainder
      word_type nq;     // dividend bits not yet used, quotient bits shifted in below
      word_type den;    // divisor magnitude
      logic     neg_q;  // negate quotient at the end
      logic     neg_r;  // negate remainder at the end
      logic     dz;     // divisor was zero
   } cell_type;

   // Two's complement negate at operand width
   function automatic word_type negate(word_type x);
      return word_type'(0) - x;
   endfunction

endpackage

// ===== sv/sud_prep.sv =====
// Front stage of the divider: turns operands into magnitudes and sign flags.
// Depends on sud_pkg.

module sud_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              req_valid,
   input  logic [sud_pkg::PORT_WIDTH-1:0]    req_dividend,
   input  logic [sud_pkg::PORT_WIDTH-1:0]    req_divisor,
   input  logic                              req_signed_mode,
   output sud_pkg::cell_type                 stage_out
);

   sud_pkg::word_type a;
   sud_pkg::word_type b;
   logic              a_neg;
   logic              b_neg;
   sud_pkg::word_type mag_b;
   sud_pkg::cell_type prep_ff;
   sud_pkg::cell_type prep_in;

   // Take magnitudes and record sign corrections
   always_comb begin
      a       = req_dividend[sud_pkg::DATA_WIDTH-1:0];
      b       = req_divisor[sud_pkg::DATA_WIDTH-1:0];
      a_neg   = req_signed_mode & a[sud_pkg::DATA_WIDTH-1];
      b_neg   = req_signed_mode & b[sud_pkg::DATA_WIDTH-1];
      mag_b   = b_neg ? sud_pkg::negate(b) : b;
      prep_in.valid = req_valid;
      prep_in.rem   = '0;
      prep_in.nq    = a_neg ? sud_pkg::negate(a) : a;
      prep_in.den   = mag_b;
      prep_in.neg_q = a_neg ^ b_neg;
      prep_in.neg_r = a_neg;
      prep_in.dz    = (mag_b == '0);
   end

   // Advance with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (adv) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_out = prep_ff;

endmodule

// ===== sv/sud_cell.sv =====
// One cell of the division chain: produces one quotient bit per item.
// Depends on sud_pkg.

module sud_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  sud_pkg::cell_type stage_in,
   output sud_pkg::cell_type stage_out
);

   logic [sud_pkg::DATA_WIDTH:0] shifted;
   logic [sud_pkg::DATA_WIDTH:0] diff;
   logic                         take;
   sud_pkg::cell_type            cell_ff;
   sud_pkg::cell_type            cell_in;

   // Shift in the next dividend bit, trial subtract, keep on no borrow
   always_comb begin
      shifted = {stage_in.rem, stage_in.nq[sud_pkg::DATA_WIDTH-1]};
      diff    = shifted - {1'b0, stage_in.den};
      take    = ~diff[sud_pkg::DATA_WIDTH];
      cell_in     = stage_in;
      cell_in.rem = take ? diff[sud_pkg::DATA_WIDTH-1:0] : shifted[sud_pkg::DATA_WIDTH-1:0];
      cell_in.nq  = {stage_in.nq[sud_pkg::DATA_WIDTH-2:0], take};
   end

   // Hand the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign stage_out = cell_ff;

`ifndef SYNTH
   // Partial remainder stays below a nonzero divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      cell_ff.valid && (cell_ff.den != '0) |-> cell_ff.rem < cell_ff.den)
      else $error("partial remainder not below divisor");

   // A frozen pipeline keeps every cell's content
   a_hold_when_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cell_ff))
      else $error("cell changed while pipeline frozen");
`endif

endmodule

// ===== sv/sud_fix.sv =====
// Back stage of the divider: applies sign and divide-by-zero fixes, holds the result.
// Depends on sud_pkg.

module sud_fix (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  sud_pkg::cell_type              stage_in,
   output logic                           rsp_valid,
   output logic [sud_pkg::PORT_WIDTH-1:0] rsp_quotient,
   output logic [sud_pkg::PORT_WIDTH-1:0] rsp_remainder,
   output logic                           rsp_divide_by_zero
);

   sud_pkg::word_type q_mag;
   sud_pkg::word_type r_mag;
   sud_pkg::word_type quotient_in;
   sud_pkg::word_type remainder_in;
   logic              valid_ff;
   sud_pkg::word_type quotient_ff;
   sud_pkg::word_type remainder_ff;
   logic              dz_ff;

   // Substitute fallback values, then restore signs
   always_comb begin
      q_mag        = stage_in.dz ? '1 : stage_in.nq;
      r_mag        = stage_in.dz ? '0 : stage_in.rem;
      quotient_in  = stage_in.neg_q ? sud_pkg::negate(q_mag) : q_mag;
      remainder_in = stage_in.neg_r ? sud_pkg::negate(r_mag) : r_mag;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quotient_ff  <= quotient_in;
         remainder_ff <= remainder_in;
         dz_ff        <= stage_in.dz;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_quotient       = sud_pkg::PORT_WIDTH'(quotient_ff);
   assign rsp_remainder      = sud_pkg::PORT_WIDTH'(remainder_ff);
   assign rsp_divide_by_zero = dz_ff;

endmodule

// ===== sv/signed_unsigned_divider_64_top.sv =====
// Top level of the signed/unsigned restoring divider.
// Depends on sud_pkg, sud_prep, sud_cell and sud_fix.

// Fully pipelined divider: one item (dividend, divisor, signed flag) is
// accepted every cycle while no result is stalled; its quotient and
// remainder pass through one operand stage, one cell per quotient bit and
// one output stage. Throughput is one item per cycle unless stalled. A stalled
// result freezes the whole chain, so req_stall follows rsp_stall while a
// result is held. Signed division truncates toward zero; the remainder takes
// the dividend's sign. Dividing by zero sets rsp_divide_by_zero and returns an
// all-ones magnitude quotient (sign-corrected) and a zero remainder.

module signed_unsigned_divider_64_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sud_pkg::PORT_WIDTH-1:0] req_dividend,
   input  logic [sud_pkg::PORT_WIDTH-1:0] req_divisor,
   input  logic                           req_signed_mode,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sud_pkg::PORT_WIDTH-1:0] rsp_quotient,
   output logic [sud_pkg::PORT_WIDTH-1:0] rsp_remainder,
   output logic                           rsp_divide_by_zero
);

   logic              adv;
   sud_pkg::cell_type chain [sud_pkg::DATA_WIDTH+1];

   // Advance everything unless a held result is stalled
   assign adv       = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;

   sud_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .req_signed_mode (req_signed_mode),
      .stage_out       (chain[0])
   );

   // One cell per quotient bit, top bit first
   for (genvar k = 0; k < sud_pkg::DATA_WIDTH; k++) begin : g_cell
      sud_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   sud_fix u_fix (
      .clock              (clock),
      .reset              (reset),
      .adv                (adv),
      .stage_in           (chain[sud_pkg::DATA_WIDTH]),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

`ifndef SYNTH
   // Division by zero always reports a zero remainder
   a_dz_rem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_remainder == '0)
      else $error("divide by zero with nonzero remainder");

   // Input is only held back by a waiting result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result waiting");
`endif

endmodule
